FILE: hdl/ils_pkg.sv
// interrupt latency statistics: shared types and constants
// no dependencies; imported by the top level and the checker
package ils_pkg;

  localparam int DIV_WIDTH  = 32;
  localparam int RATE_WIDTH = 20;

  localparam logic [DIV_WIDTH-1:0]  MICROS_PER_SECOND = 32'd1000000;
  localparam logic [RATE_WIDTH-1:0] RATE_RESET        = 20'd1000;

  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_SERVICE = 2'd1;
  localparam logic [1:0] REQ_STOP    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PERIOD_GO,
    ST_PERIOD_WAIT,
    ST_DELAY,
    ST_UPDATE,
    ST_CHECK,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_REPORT
  } state_t;

endpackage

FILE: hdl/ils_div.sv
// shared radix-2 restoring divider, one quotient bit per cycle
// standalone; used for the period and the average
module ils_div #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvs;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] quo_next;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  always_comb begin
    shifted = {rem, quo[WIDTH-1]};
    diff    = shifted - {1'b0, dvs};
    if (!diff[WIDTH]) begin
      rem_next = diff[WIDTH-1:0];
      quo_next = {quo[WIDTH-2:0], 1'b1};
    end else begin
      rem_next = shifted[WIDTH-1:0];
      quo_next = {quo[WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

FILE: hdl/interrupt_latency_statistics_top.sv
// interrupt latency statistics top level: sequencer, statistics registers
// depends on ils_pkg and ils_div
// path to the result beat: a service while running passes delay and update, start the period
// division on the 32-step shared divider; then check, and with samples held and no overflow
// the average division, else straight to report; one request at a time, the next taken the
// cycle after the result loads; synchronous reset clears stats, rate to 1000 Hz
module interrupt_latency_statistics_top import ils_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RATE_WIDTH-1:0] sample_rate_hz,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [1:0]            req_type,
  input  logic [31:0]           now_time,
  input  logic [31:0]           rearm_time,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [31:0]           min_delay,
  output logic [31:0]           max_delay,
  output logic [31:0]           avg_delay,
  output logic                  overflowed,
  output logic [31:0]           next_deadline
);

  localparam int TW = TIME_WIDTH;

  state_t state;
  state_t state_next;

  logic [RATE_WIDTH-1:0] rate;
  logic [RATE_WIDTH-1:0] rate_eff;
  logic [TW-1:0]         now_q;
  logic [TW-1:0]         rearm_q;
  logic                  running;
  logic [TW-1:0]         deadline;
  logic [RATE_WIDTH-1:0] period_us;
  logic [TW-1:0]         min_seen;
  logic [TW-1:0]         max_seen;
  logic [31:0]           delay_sum;
  logic [31:0]           sample_count;
  logic                  sum_overflow;
  logic [TW-1:0]         delay_q;
  logic [31:0]           avg_q;

  logic                  div_start;
  logic [DIV_WIDTH-1:0]  div_dividend;
  logic [DIV_WIDTH-1:0]  div_divisor;
  logic                  div_done;
  logic [DIV_WIDTH-1:0]  div_quotient;

  logic [TW+31:0]         now_wide;
  logic [TW+31:0]         rearm_wide;
  logic [RATE_WIDTH-1:0]  period_src;
  logic [TW+RATE_WIDTH-1:0] period_wide;
  logic [TW-1:0]          deadline_new;
  logic [TW+31:0]         delay_wide;
  logic [TW-1:0]          delay_hi;
  logic [31:0]            delay_lo;
  logic [32:0]            sum33;
  logic                   sum_ok;
  logic [TW+31:0]         min_wide;
  logic [TW+31:0]         max_wide;
  logic [TW+31:0]         dl_wide;
  logic                   res_load;

  assign cfg_ready = 1'b1;

  // time alignment to the configured width
  assign now_wide    = {{TW{1'b0}}, now_time};
  assign rearm_wide  = {{TW{1'b0}}, rearm_time};
  assign period_src  = (state == ST_PERIOD_WAIT) ? div_quotient[RATE_WIDTH-1:0] : period_us;
  assign period_wide = {{TW{1'b0}}, period_src};
  assign deadline_new = rearm_q + period_wide[TW-1:0];

  assign delay_wide = {32'd0, delay_q};
  assign delay_hi   = delay_wide[TW+31:32];
  assign delay_lo   = delay_wide[31:0];
  assign sum33      = {1'b0, delay_sum} + {1'b0, delay_lo};
  assign sum_ok     = (delay_hi == '0) && !sum33[32] && (sample_count != '1);

  assign rate_eff = (rate == '0) ? RATE_WIDTH'(1) : rate;

  assign min_wide = {32'd0, min_seen};
  assign max_wide = {32'd0, max_seen};
  assign dl_wide  = {32'd0, deadline};

  assign res_load = (state == ST_REPORT) && (!res_valid || !res_stall);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          unique case (req_type)
            REQ_START:   state_next = ST_PERIOD_GO;
            REQ_SERVICE: state_next = running ? ST_DELAY : ST_CHECK;
            default:     state_next = ST_CHECK;
          endcase
        end
      end
      ST_PERIOD_GO:   state_next = ST_PERIOD_WAIT;
      ST_PERIOD_WAIT: if (div_done) state_next = ST_CHECK;
      ST_DELAY:       state_next = ST_UPDATE;
      ST_UPDATE:      state_next = ST_CHECK;
      ST_CHECK: begin
        if (sum_overflow || (sample_count == '0)) begin
          state_next = ST_REPORT;
        end else begin
          state_next = ST_AVG_GO;
        end
      end
      ST_AVG_GO:      state_next = ST_AVG_WAIT;
      ST_AVG_WAIT:    if (div_done) state_next = ST_REPORT;
      ST_REPORT:      if (!res_valid || !res_stall) state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_stall    = 1'b1;
    div_start    = 1'b0;
    div_dividend = delay_sum;
    div_divisor  = sample_count;
    unique case (state)
      ST_IDLE:      req_stall = 1'b0;
      ST_PERIOD_GO: begin
        div_start    = 1'b1;
        div_dividend = MICROS_PER_SECOND + DIV_WIDTH'(rate_eff >> 1);
        div_divisor  = DIV_WIDTH'(rate_eff);
      end
      ST_AVG_GO:    div_start = 1'b1;
      ST_PERIOD_WAIT, ST_DELAY, ST_UPDATE, ST_CHECK, ST_AVG_WAIT, ST_REPORT: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rate         <= RATE_RESET;
      running      <= 1'b0;
      deadline     <= '0;
      period_us    <= '0;
      min_seen     <= '1;
      max_seen     <= '0;
      delay_sum    <= '0;
      sample_count <= '0;
      sum_overflow <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        rate <= sample_rate_hz;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            now_q   <= now_wide[TW-1:0];
            rearm_q <= rearm_wide[TW-1:0];
            if (req_type == REQ_STOP) begin
              running <= 1'b0;
            end
          end
        end
        ST_PERIOD_WAIT: begin
          if (div_done) begin
            period_us    <= div_quotient[RATE_WIDTH-1:0];
            deadline     <= deadline_new;
            running      <= 1'b1;
            min_seen     <= '1;
            max_seen     <= '0;
            delay_sum    <= '0;
            sample_count <= '0;
            sum_overflow <= 1'b0;
          end
        end
        ST_DELAY: delay_q <= now_q - deadline;
        ST_UPDATE: begin
          if (delay_q < min_seen) begin
            min_seen <= delay_q;
          end
          if (delay_q > max_seen) begin
            max_seen <= delay_q;
          end
          if (!sum_overflow) begin
            if (sum_ok) begin
              delay_sum    <= sum33[31:0];
              sample_count <= sample_count + 32'd1;
            end else begin
              sum_overflow <= 1'b1;
            end
          end
          deadline <= deadline_new;
        end
        ST_CHECK: avg_q <= sum_overflow ? '1 : '0;
        ST_AVG_WAIT: begin
          if (div_done) begin
            avg_q <= div_quotient;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (res_load) begin
      min_delay     <= min_wide[31:0];
      max_delay     <= max_wide[31:0];
      avg_delay     <= avg_q;
      overflowed    <= sum_overflow;
      next_deadline <= dl_wide[31:0];
    end
  end

  ils_div #(
    .WIDTH (DIV_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

FILE: hdl/ils_checker.sv
// port-level checks for the interrupt latency statistics top level
// depends on ils_pkg; bound to interrupt_latency_statistics_top below
module ils_checker import ils_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [RATE_WIDTH-1:0] sample_rate_hz,
  input logic                  req_valid,
  input logic                  req_stall,
  input logic [1:0]            req_type,
  input logic [31:0]           now_time,
  input logic [31:0]           rearm_time,
  input logic                  res_valid,
  input logic                  res_stall,
  input logic [31:0]           min_delay,
  input logic [31:0]           max_delay,
  input logic [31:0]           avg_delay,
  input logic                  overflowed,
  input logic [31:0]           next_deadline
);

  // stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(avg_delay) && $stable(min_delay))
    else $error("stalled result beat changed");

  // no result beat straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result beat after reset");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while busy");

  // overflow forces the average to all ones
  a_overflow_avg: assert property (@(posedge clk) disable iff (rst)
    res_valid && overflowed |-> avg_delay == 32'hFFFF_FFFF)
    else $error("average not saturated after overflow");

  // average never exceeds the maximum
  a_avg_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid && !overflowed |-> avg_delay <= max_delay)
    else $error("average above maximum");

endmodule

bind interrupt_latency_statistics_top ils_checker u_ils_checker (.*);
